// ===== src/b64le_pkg.sv =====
package b64le_pkg;

  localparam logic [7:0] LIMIT_RESET = 8'd76;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_PAD    = 8'd61;
  localparam int unsigned MAX_CHARS  = 6;

  // characters produced by one request, slot 0 goes out first
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                cnt;
    logic                      msg_end;
  } b64le_res_t;

  // base64 alphabet lookup: A-Z a-z 0-9 + /
  function automatic logic [7:0] sextet_char(input logic [5:0] idx);
    logic [7:0] e;
    logic [7:0] ch;
    e = {2'b00, idx};
    case (idx) inside
      [6'd0:6'd25]:  ch = 8'd65 + e;
      [6'd26:6'd51]: ch = 8'd71 + e;
      [6'd52:6'd61]: ch = e - 8'd4;
      6'd62:         ch = 8'd43;
      default:       ch = 8'd47;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/b64le_group.sv =====
module b64le_group (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             line_limit,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  logic                   accept,
  output b64le_pkg::b64le_res_t  res
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  line_r, line_nxt;

  logic [8:0]  sum;
  logic        wrap;
  logic [23:0] grp;

  assign sum  = {1'b0, line_r} + 9'd4;
  assign wrap = (sum >= {1'b0, line_limit});

  always_comb begin
    res       = '0;
    grp       = '0;
    held_nxt  = held_r;
    phase_nxt = phase_r;
    line_nxt  = line_r;
    if (phase_r[1]) begin
      // full group; phase code 3 never occurs and acts like 2
      grp = {held_r, data_byte};
      res.chars[0] = b64le_pkg::sextet_char(grp[23:18]);
      res.chars[1] = b64le_pkg::sextet_char(grp[17:12]);
      res.chars[2] = b64le_pkg::sextet_char(grp[11:6]);
      res.chars[3] = b64le_pkg::sextet_char(grp[5:0]);
      if (wrap) begin
        res.chars[4] = b64le_pkg::CHAR_CR;
        res.chars[5] = b64le_pkg::CHAR_LF;
        res.cnt      = 3'd6;
        line_nxt     = '0;
      end else begin
        res.cnt  = 3'd4;
        line_nxt = sum[7:0];
      end
      res.msg_end = last_byte;
      held_nxt    = '0;
      phase_nxt   = '0;
      if (last_byte) begin
        line_nxt = '0;
      end
    end else if (!last_byte) begin
      held_nxt  = {held_r[7:0], data_byte};
      phase_nxt = phase_r + 2'd1;
    end else begin
      // short tail, zero filled and padded
      grp = phase_r[0] ? {held_r[7:0], data_byte, 8'h00} : {data_byte, 16'h0000};
      res.chars[0] = b64le_pkg::sextet_char(grp[23:18]);
      res.chars[1] = b64le_pkg::sextet_char(grp[17:12]);
      res.chars[2] = phase_r[0] ? b64le_pkg::sextet_char(grp[11:6]) : b64le_pkg::CHAR_PAD;
      res.chars[3] = b64le_pkg::CHAR_PAD;
      res.cnt      = 3'd4;
      res.msg_end  = 1'b1;
      held_nxt     = '0;
      phase_nxt    = '0;
      line_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      phase_r <= '0;
      line_r  <= '0;
    end else if (accept) begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// ===== src/b64le_emit.sv =====
module b64le_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  b64le_pkg::b64le_res_t  res,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  logic [b64le_pkg::MAX_CHARS-1:0][7:0] chars_r, chars_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       msg_r, msg_nxt;
  logic       take;

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = chars_r[0];
  assign out_tlast  = (cnt_r == 3'd1);
  assign out_tuser  = msg_r && (cnt_r == 3'd1);
  assign take       = out_tvalid && out_tready;
  // buffer can take a new request when empty or on its final char going out
  assign free       = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);

  always_comb begin
    chars_nxt = chars_r;
    cnt_nxt   = cnt_r;
    msg_nxt   = msg_r;
    if (take) begin
      chars_nxt = {8'h00, chars_r[b64le_pkg::MAX_CHARS-1:1]};
      cnt_nxt   = cnt_r - 3'd1;
    end
    if (load) begin
      chars_nxt = res.chars;
      cnt_nxt   = res.cnt;
      msg_nxt   = res.msg_end;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    msg_r   <= msg_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/base64_line_wrapped_encoder_unit.sv =====
// An accepted byte that yields characters shows its first one on the output in
//   the cycle after it is accepted; one character per cycle goes out while
//   out_tready is high. A full group gives 4 or 6 characters, and bytes that
//   complete no group are taken even while the output drains.
// Reset (rst_n low, synchronous): output buffer emptied, group state and line
//   count cleared, line_limit back to 76.
module base64_line_wrapped_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,   // line_limit
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // run_end
  output logic       out_tuser   // [0] message_end
);

  logic [7:0]            limit_r;
  b64le_pkg::b64le_res_t res;
  logic                  free;
  logic                  accept;
  logic                  has_chars;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= b64le_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  assign has_chars = (res.cnt != 3'd0);
  assign in_tready = free || !has_chars;
  assign accept    = in_tvalid && in_tready;

  b64le_group u_group (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_limit (limit_r),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .accept     (accept),
    .res        (res)
  );

  b64le_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && has_chars),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/b64le_check.sv =====
module b64le_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  a_msg_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("message end not on last char of its run");

  a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == b64le_pkg::CHAR_CR |-> !out_tlast)
    else $error("CR ended a run without LF");

  a_tail_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("final byte produced no output");

endmodule

bind base64_line_wrapped_encoder_unit b64le_check u_b64le_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== sim/tb_base64_line_wrapped_encoder_unit.sv =====
module tb_base64_line_wrapped_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 40;
  localparam int NUM_DIR      = 24;

  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
  } enc_char_t;

  // typed_n == 0: expectation comes from the encoder model below
  typedef struct packed {
    logic        wr_cfg;
    logic [7:0]  limit;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  typed_n;
    logic [47:0] typed_chars;  // first char in the top byte
  } dir_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = '0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  // encoder model state
  logic [15:0] pend_bytes = '0;
  logic [1:0]  pend_cnt   = '0;
  logic [7:0]  col_count  = '0;
  logic [7:0]  wrap_limit = b64le_pkg::LIMIT_RESET;

  enc_char_t expected_chars[$];

  int errors        = 0;
  int bytes_sent    = 0;
  int messages_sent = 0;
  int chars_checked = 0;
  int limit_writes  = 0;
  int stall_cnt     = 0;
  int send_idle     = 0;
  int recv_idle     = 0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{1'b0, 8'd0,   8'h00, 1'b1, 3'd4, {"AA==", 16'h0}},
    '{1'b0, 8'd0,   8'hFF, 1'b1, 3'd4, {"/w==", 16'h0}},
    '{1'b0, 8'd0,   8'hFF, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'hFF, 1'b1, 3'd4, {"//8=", 16'h0}},
    '{1'b0, 8'd0,   8'h00, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'h00, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'h00, 1'b1, 3'd4, {"AAAA", 16'h0}},
    '{1'b0, 8'd0,   8'hFF, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'hFF, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'hFF, 1'b1, 3'd4, {"////", 16'h0}},
    // wrap after every group; message ending on the LF
    '{1'b1, 8'd4,   8'h00, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'h00, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'h00, 1'b1, 3'd6, {"AAAA", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF}},
    '{1'b0, 8'd0,   8'hFF, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'hFF, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'hFF, 1'b0, 3'd6, {"////", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF}},
    '{1'b0, 8'd0,   8'hFF, 1'b1, 3'd4, {"/w==", 16'h0}},
    // limit below four, then the top limit of 255
    '{1'b1, 8'd0,   8'h12, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'h34, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'h56, 1'b1, 3'd0, 48'h0},
    '{1'b1, 8'd255, 8'hAB, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'hCD, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'hEF, 1'b0, 3'd0, 48'h0},
    '{1'b0, 8'd0,   8'h01, 1'b1, 3'd0, 48'h0}
  };

  base64_line_wrapped_encoder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] b64_char(input logic [23:0] grp, input int shift);
    logic [5:0] idx;
    idx = grp[shift +: 6];
    return B64_ALPHABET[511 - 8 * idx -: 8];
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic lst,
                             output int n, output logic [5:0][7:0] ch);
    logic [23:0] grp;
    logic [8:0]  sum;
    n  = 0;
    ch = '0;
    if (pend_cnt >= 2'd2) begin
      grp   = {pend_bytes, b};
      ch[0] = b64_char(grp, 18);
      ch[1] = b64_char(grp, 12);
      ch[2] = b64_char(grp, 6);
      ch[3] = b64_char(grp, 0);
      // 9-bit compare, no wrap near the top
      sum = {1'b0, col_count} + 9'd4;
      if (sum >= {1'b0, wrap_limit}) begin
        ch[4]     = b64le_pkg::CHAR_CR;
        ch[5]     = b64le_pkg::CHAR_LF;
        n         = 6;
        col_count = '0;
      end else begin
        n         = 4;
        col_count = sum[7:0];
      end
      pend_bytes = '0;
      pend_cnt   = '0;
    end else if (!lst) begin
      pend_bytes = {pend_bytes[7:0], b};
      pend_cnt   = pend_cnt + 2'd1;
    end else begin
      grp   = (pend_cnt == 2'd0) ? {b, 16'h0} : {pend_bytes[7:0], b, 8'h00};
      ch[0] = b64_char(grp, 18);
      ch[1] = b64_char(grp, 12);
      ch[2] = (pend_cnt == 2'd1) ? b64_char(grp, 6) : b64le_pkg::CHAR_PAD;
      ch[3] = b64le_pkg::CHAR_PAD;
      n     = 4;
    end
    if (lst) begin
      pend_bytes = '0;
      pend_cnt   = '0;
      col_count  = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input logic [2:0] typed_n = '0,
                           input logic [47:0] typed_chars = '0);
    int              n;
    logic [5:0][7:0] ch;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= b;
    in_tlast  <= lst;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_byte(b, lst, n, ch);
    if (typed_n != 0) begin
      n = typed_n;
      for (int k = 0; k < 6; k++) ch[k] = typed_chars[47 - 8 * k -: 8];
    end
    for (int k = 0; k < n; k++)
      expected_chars.push_back(enc_char_t'{ch[k], k == n - 1, lst && (k == n - 1)});
    bytes_sent++;
    if (lst) messages_sent++;
  endtask

  // let the output drain and any byte still in flight settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    wait_drained();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    wrap_limit = v;
    limit_writes++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    enc_char_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("out_char: no character expected, got %h", out_tdata);
        errors++;
      end else begin
        exp_c = expected_chars.pop_front();
        chars_checked++;
        if (out_tdata !== exp_c.ch) begin
          $error("out_char: expected %h, got %h", exp_c.ch, out_tdata);
          errors++;
        end
        if (out_tlast !== exp_c.run_end) begin
          $error("run_end: expected %b, got %b", exp_c.run_end, out_tlast);
          errors++;
        end
        if (out_tuser !== exp_c.msg_end) begin
          $error("message_end: expected %b, got %b", exp_c.msg_end, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a request", STALL_LIMIT);
      $display("tb_base64_line_wrapped_encoder_unit failed");
      $finish;
    end
  end

  initial begin
    int         phase_bytes;
    int         len;
    int         pick;
    logic [7:0] lim;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 33;
    recv_idle = 65;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg) write_limit(dir_rows[i].limit);
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed_n,
                dir_rows[i].typed_chars);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle   = (ph == 0) ? 33 : (ph == 1) ? 65 : 0;
      recv_idle   = (ph == 0) ? 65 : (ph == 1) ? 33 : 0;
      phase_bytes = 0;
      if (ph == 2) begin
        // long line at the top limit: count reaches 252 before the wrap
        write_limit(8'd255);
        for (int k = 0; k < 195; k++) send_byte(8'($urandom_range(0, 255)), k == 194);
        phase_bytes = 195;
      end
      while (phase_bytes < PHASE_BYTES) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 7))
            0:       lim = 8'd0;
            1:       lim = 8'($urandom_range(1, 3));
            2:       lim = 8'd4;
            3:       lim = 8'd76;
            4:       lim = 8'd252;
            5:       lim = 8'd255;
            default: lim = 8'($urandom_range(4, 252));
          endcase
          write_limit(lim);
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
          len = $urandom_range(1, 8);
        else if (pick < 9)
          len = $urandom_range(9, 30);
        else
          len = $urandom_range(57, 80);
        for (int k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)), k == len - 1);
        phase_bytes += len;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("encoded %0d bytes in %0d messages, checked %0d characters",
             bytes_sent, messages_sent, chars_checked);
    $display("line limit written %0d times, idle mixes 33/65, 65/33 and none",
             limit_writes);
    if (errors == 0)
      $display("tb_base64_line_wrapped_encoder_unit passed");
    else
      $display("tb_base64_line_wrapped_encoder_unit failed");
    $finish;
  end

endmodule
